// File: hdl/bma_pkg.sv
// ----------------------------------------------------------------------------
// bma_pkg
// Shared defaults and result codes of the block map allocator.
// ----------------------------------------------------------------------------
package bma_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int BLOCK_BYTES_DEF   = 32;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam int PCT_W  = 7;
    localparam int OFFS_W = 16;

endpackage

// File: hdl/bma_ram.sv
// ----------------------------------------------------------------------------
// bma_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bma_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = bma_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/block_map_allocator.sv
// ----------------------------------------------------------------------------
// block_map_allocator
// Fixed-block allocator over a RAM map of per-block run lengths.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                   tuser
// s_axis   in   [15:0] size_bytes [31:16] release_offset mode
// m_axis   out  [1:0] status [17:2] granted_offset       -
//               [24:18] used_percent
//
// One transaction at a time. Allocate scans the map downward from its top entry,
// then marks the run it found; free clears the run from the released block.
// Zero-size, out-of-range and oversize requests do not touch the map.
// Scans, marks and clears use the map RAM port one entry per cycle; the next
// transaction can be taken in the cycle after the result is loaded.
// After reset a clearing pass over all map entries holds s_axis_tready low.
// A finished result waits in the output register; the result after it waits
// in its last state until m_axis_tready frees the register.
// ----------------------------------------------------------------------------
module block_map_allocator #(
    parameter int TABLE_ENTRIES = bma_pkg::TABLE_ENTRIES_DEF,
    parameter int BLOCK_BYTES   = bma_pkg::BLOCK_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] size_bytes, [31:16] release_offset
    input  logic        s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [1:0] status, [17:2] granted_offset,
                                        // [24:18] used_percent
);

    localparam int AW   = $clog2(TABLE_ENTRIES);
    localparam int MW   = $clog2(TABLE_ENTRIES + 1);
    localparam int PW   = $clog2(TABLE_ENTRIES * 100 + 1);
    localparam int DW   = (PW > 17) ? PW : 17;
    localparam int QW   = 17;
    localparam int BSH  = QW + $clog2(BLOCK_BYTES);
    localparam longint BMUL = ((longint'(1) << BSH) + longint'(BLOCK_BYTES - 1))
                              / longint'(BLOCK_BYTES);
    localparam int BPW  = QW + QW + 2;
    localparam int TSH  = PW + $clog2(TABLE_ENTRIES);
    localparam longint TMUL = ((longint'(1) << TSH) + longint'(TABLE_ENTRIES - 1))
                              / longint'(TABLE_ENTRIES);
    localparam int TPW  = PW + PW + 2;
    localparam int BW   = $clog2(BLOCK_BYTES + 1);
    localparam int GW   = AW + BW;
    localparam int GPW  = (GW > 16) ? GW : 16;
    localparam logic [31:0] POOL_BYTES = 32'(TABLE_ENTRIES * BLOCK_BYTES);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_DISP  = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_MARK  = 4'd5;
    localparam logic [3:0] S_FREE  = 4'd6;
    localparam logic [3:0] S_PCTL  = 4'd7;
    localparam logic [3:0] S_PCT   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0]    r_state;
    logic          r_mode;
    logic [DW-1:0] r_quo;
    logic [MW-1:0] r_need;
    logic [MW-1:0] r_run;
    logic [MW-1:0] r_left;
    logic [MW-1:0] r_used;
    logic [AW-1:0] r_raddr;
    logic [AW-1:0] r_daddr;
    logic [AW-1:0] r_waddr;
    logic          r_issue;
    logic          r_rd_vld;
    logic          r_first;
    logic [1:0]    r_status;
    logic [15:0]   r_grant;
    logic          r_ovalid;
    logic [31:0]   r_odata;

    logic [15:0]   w_size;
    logic [15:0]   w_offs;
    logic [BPW-1:0] w_bprod;
    logic [TPW-1:0] w_tprod;
    logic [PW-1:0] w_pct_prod;
    logic [GPW-1:0] w_gprod;
    logic [MW-1:0] w_rdata;
    logic [MW-1:0] n_run;
    logic [MW-1:0] w_eff;
    logic [MW-1:0] n_left;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [MW-1:0] w_wdata;
    logic          w_re;
    logic          w_out_free;

    assign w_size = s_axis_tdata[15:0];
    assign w_offs = s_axis_tdata[31:16];

    // reciprocal multiplication by constants, exact over the dividend range
    assign w_bprod = BPW'(r_quo[QW-1:0]) * BPW'(BMUL);
    assign w_tprod = TPW'(r_quo[PW-1:0]) * TPW'(TMUL);

    assign w_pct_prod = PW'(r_used) * PW'(7'd100);
    assign w_gprod    = GPW'(r_daddr) * GPW'(BLOCK_BYTES);

    assign n_run  = (w_rdata == '0) ? r_run + MW'(1) : '0;
    assign w_eff  = r_first ? w_rdata : r_left;
    assign n_left = w_eff - MW'(1);

    assign w_out_free = !r_ovalid || m_axis_tready;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_waddr;
        w_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
            end
            S_MARK: begin
                w_we    = 1'b1;
                w_wdata = r_need;
            end
            S_FREE: begin
                w_we    = r_rd_vld && (w_eff != '0);
                w_waddr = r_daddr;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign w_re = ((r_state == S_SCAN) || (r_state == S_FREE)) && r_issue;

    bma_ram #(
        .WIDTH (MW),
        .DEPTH (TABLE_ENTRIES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_waddr  <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            if (m_axis_tready && (r_state != S_FIN)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_waddr <= r_waddr + AW'(1);
                    if (r_waddr == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_mode  <= s_axis_tuser;
                        r_grant <= '0;
                        priority if (!s_axis_tuser && w_size == '0) begin
                            r_status <= bma_pkg::ST_ZERO;
                            r_state  <= S_PCTL;
                        end else if (s_axis_tuser && 32'(w_offs) >= POOL_BYTES) begin
                            r_status <= bma_pkg::ST_RANGE;
                            r_state  <= S_PCTL;
                        end else if (s_axis_tuser) begin
                            r_status <= bma_pkg::ST_OK;
                            r_quo    <= DW'(w_offs);
                            r_state  <= S_DIV;
                        end else begin
                            r_status <= bma_pkg::ST_OK;
                            r_quo    <= DW'(w_size) + DW'(BLOCK_BYTES - 1);
                            r_state  <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_quo   <= DW'(w_bprod >> BSH);
                    r_state <= S_DISP;
                end
                S_DISP: begin
                    r_issue  <= 1'b1;
                    r_rd_vld <= 1'b0;
                    r_first  <= 1'b1;
                    r_run    <= '0;
                    if (r_mode) begin
                        r_raddr <= r_quo[AW-1:0];
                        r_state <= S_FREE;
                    end else if (r_quo > DW'(TABLE_ENTRIES)) begin
                        r_status <= bma_pkg::ST_NOFIT;
                        r_state  <= S_PCTL;
                    end else begin
                        r_need  <= r_quo[MW-1:0];
                        r_raddr <= LAST_IDX;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_issue) begin
                        r_daddr  <= r_raddr;
                        r_rd_vld <= 1'b1;
                        r_raddr  <= r_raddr - AW'(1);
                        if (r_raddr == '0) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (r_rd_vld) begin
                        r_run <= n_run;
                        if (n_run == r_need) begin
                            r_grant <= w_gprod[15:0];
                            r_waddr <= r_daddr;
                            r_left  <= r_need;
                            r_used  <= r_used + r_need;
                            r_state <= S_MARK;
                        end else if (r_daddr == '0) begin
                            r_status <= bma_pkg::ST_NOFIT;
                            r_state  <= S_PCTL;
                        end
                    end
                end
                S_MARK: begin
                    r_waddr <= r_waddr + AW'(1);
                    r_left  <= r_left - MW'(1);
                    if (r_left == MW'(1)) begin
                        r_state <= S_PCTL;
                    end
                end
                S_FREE: begin
                    if (r_issue) begin
                        r_daddr  <= r_raddr;
                        r_rd_vld <= 1'b1;
                        r_raddr  <= r_raddr + AW'(1);
                        if (r_raddr == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (r_rd_vld) begin
                        r_first <= 1'b0;
                        r_left  <= n_left;
                        if (w_eff == '0) begin
                            r_state <= S_PCTL;
                        end else begin
                            if (w_rdata != '0) begin
                                r_used <= r_used - MW'(1);
                            end
                            if (n_left == '0 || r_daddr == LAST_IDX) begin
                                r_state <= S_PCTL;
                            end
                        end
                    end
                end
                S_PCTL: begin
                    r_issue <= 1'b0;
                    r_quo   <= DW'(w_pct_prod);
                    r_state <= S_PCT;
                end
                S_PCT: begin
                    r_quo   <= DW'(w_tprod >> TSH);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {7'd0, r_quo[bma_pkg::PCT_W-1:0], r_grant, r_status};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("input taken during map clearing pass");

    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= MW'(TABLE_ENTRIES))
        else $error("used block count beyond table size");

    a_mark_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> (32'(r_waddr) + 32'(r_left) <= 32'(TABLE_ENTRIES)))
        else $error("run marking runs past table end");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[24:18] <= 7'd100))
        else $error("used percentage above 100");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state != S_IDLE))
        else $error("accepted transaction not started");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Block map allocator: directed edge cases, then a long random mix of allocate
// and release transactions. A scoreboard model of the run map predicts status,
// granted offset and occupancy for every accepted transaction; results are
// checked in order while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    import bma_pkg::*;

    localparam int TBL          = TABLE_ENTRIES_DEF;
    localparam int BLK          = BLOCK_BYTES_DEF;
    localparam int POOL_BYTES   = TBL * BLK;
    localparam int DRAIN_CYCLES = 600;
    localparam int IDLE_LIMIT   = 8000;
    localparam int RANDOM_ITEMS = 1150;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_e;

    typedef struct packed {
        logic [1:0]        status;
        logic [OFFS_W-1:0] grant;
        logic [PCT_W-1:0]  pct;
    } alloc_rec_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [15:0] size_bytes, [31:16] release_offset
    logic        s_axis_tuser;   // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [1:0] status, [17:2] granted_offset, [24:18] used_percent

    logic [8:0]  block_runs [TBL];
    alloc_rec_t  pending_results [$];
    int          live_offsets [$];
    bit          no_idle;
    int          errors;
    int          n_allocs, n_granted, n_nofit, n_zero;
    int          n_frees, n_range, peak_pct;

    block_map_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        if (r < 98)
            return $urandom_range(15, 4);
        return $urandom_range(80, 20);
    endfunction

    function automatic alloc_rec_t allocator_outcome(op_e op, logic [15:0] size,
                                                     logic [15:0] offs);
        alloc_rec_t res;
        int need, run, pos, idx, cnt, used, j;
        res = '0;
        res.status = ST_OK;
        if (op == OP_ALLOC) begin
            n_allocs++;
            if (size == 16'd0) begin
                res.status = ST_ZERO;
            end else begin
                need = (int'(size) + BLK - 1) / BLK;
                res.status = ST_NOFIT;
                run = 0;
                if (need <= TBL) begin
                    for (pos = TBL - 1; pos >= 0; pos--) begin
                        if (block_runs[pos] == 9'd0)
                            run++;
                        else
                            run = 0;
                        if (run == need) begin
                            for (j = 0; j < need; j++)
                                block_runs[pos + j] = 9'(need);
                            res.grant  = 16'(pos * BLK);
                            res.status = ST_OK;
                            break;
                        end
                    end
                end
            end
        end else begin
            n_frees++;
            if (int'(offs) >= POOL_BYTES) begin
                res.status = ST_RANGE;
            end else begin
                idx = int'(offs) / BLK;
                cnt = block_runs[idx];
                for (j = 0; j < cnt && idx + j < TBL; j++)
                    block_runs[idx + j] = 9'd0;
            end
        end
        used = 0;
        foreach (block_runs[k])
            if (block_runs[k] != 9'd0)
                used++;
        res.pct = 7'(used * 100 / TBL);
        case (res.status)
            ST_OK:    if (op == OP_ALLOC) n_granted++;
            ST_NOFIT: n_nofit++;
            ST_ZERO:  n_zero++;
            ST_RANGE: n_range++;
            default: ;
        endcase
        if (res.pct > peak_pct)
            peak_pct = res.pct;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 30)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task automatic send_request(input op_e op, input logic [15:0] size,
                                input logic [15:0] offs, output alloc_rec_t outcome);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {offs, size};
        s_axis_tuser  <= op;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        outcome = allocator_outcome(op, size, offs);
        pending_results.push_back(outcome);
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // whole-table grant, clearing clamped at the table end, full release
    task automatic test_full_table_run();
        alloc_rec_t r;
        send_request(OP_ALLOC, 16'(POOL_BYTES), 16'($urandom), r);
        send_request(OP_ALLOC, 16'd1, 16'($urandom), r);
        send_request(OP_FREE, 16'($urandom), 16'(200 * BLK), r);
        send_request(OP_ALLOC, 16'(2 * BLK), 16'($urandom), r);
        send_request(OP_FREE, 16'($urandom), 16'd0, r);
    endtask

    task automatic test_request_edges();
        alloc_rec_t r;
        send_request(OP_ALLOC, 16'd0, 16'($urandom), r);
        send_request(OP_ALLOC, 16'hFFFF, 16'($urandom), r);
        send_request(OP_ALLOC, 16'(POOL_BYTES + 1), 16'($urandom), r);
        send_request(OP_ALLOC, 16'd1, 16'($urandom), r);
        send_request(OP_ALLOC, 16'(BLK), 16'($urandom), r);
        send_request(OP_ALLOC, 16'(BLK + 1), 16'($urandom), r);
        send_request(OP_ALLOC, 16'(4 * BLK), 16'($urandom), r);
        send_request(OP_ALLOC, 16'(POOL_BYTES), 16'($urandom), r);
    endtask

    // out of pool, last block, unaligned, already free, inside a run
    task automatic test_release_edges();
        alloc_rec_t r;
        send_request(OP_FREE, 16'($urandom), 16'(POOL_BYTES), r);
        send_request(OP_FREE, 16'($urandom), 16'hFFFF, r);
        send_request(OP_FREE, 16'($urandom), 16'(POOL_BYTES - 1), r);
        send_request(OP_FREE, 16'($urandom), 16'(253 * BLK + 7), r);
        send_request(OP_FREE, 16'($urandom), 16'd0, r);
        send_request(OP_FREE, 16'($urandom), 16'(249 * BLK), r);
        send_request(OP_FREE, 16'($urandom), 16'(248 * BLK), r);
    endtask

    task automatic test_drain_pause();
        alloc_rec_t r;
        no_idle = 1'b1;
        repeat (3)
            send_request(OP_ALLOC, 16'($urandom_range(300, 1)), 16'($urandom), r);
        no_idle = 1'b0;
        wait_results_drained();
        send_request(OP_FREE, 16'($urandom), 16'(r.grant), r);
    endtask

    task automatic test_random_mix(input int count);
        alloc_rec_t r;
        op_e        op;
        logic [15:0] size, offs;
        int         alloc_pct, sel, idx;
        for (int i = 0; i < count; i++) begin
            no_idle = ((i / 97) % 5) == 3;
            case ((i / 150) % 3)
                0:       alloc_pct = 50;
                1:       alloc_pct = 80;
                default: alloc_pct = 25;
            endcase
            op   = ($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_FREE;
            size = 16'($urandom);
            offs = 16'($urandom);
            sel  = $urandom_range(99);
            if (op == OP_ALLOC) begin
                if (sel < 70)
                    size = 16'($urandom_range(256, 1));
                else if (sel < 85)
                    size = 16'($urandom_range(2048, 1));
                else if (sel < 90)
                    size = 16'd0;
                else if (sel < 95)
                    size = 16'(BLK * $urandom_range(16, 1));
            end else begin
                if (sel < 60 && live_offsets.size() > 0) begin
                    idx  = $urandom_range(live_offsets.size() - 1);
                    offs = 16'(live_offsets[idx]);
                    live_offsets.delete(idx);
                    if ($urandom_range(9) == 0)
                        offs = offs + 16'($urandom_range(BLK - 1));
                end else if (sel < 90) begin
                    offs = 16'($urandom_range(POOL_BYTES - 1));
                end
            end
            send_request(op, size, offs, r);
            if (op == OP_ALLOC && r.status == ST_OK)
                live_offsets.push_back(int'(r.grant));
            if (i % 300 == 299)
                wait_results_drained();
        end
    endtask

    always @(posedge i_clk) begin : check_results
        alloc_rec_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no transaction outstanding");
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[1:0] !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_axis_tdata[1:0], want.status));
                if (m_axis_tdata[17:2] !== want.grant)
                    report_mismatch($sformatf("granted_offset got %0d want %0d",
                                              m_axis_tdata[17:2], want.grant));
                if (m_axis_tdata[24:18] !== want.pct)
                    report_mismatch($sformatf("used_percent got %0d want %0d",
                                              m_axis_tdata[24:18], want.pct));
            end
        end
    end

    initial begin : sink_stall
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        errors    = 0;
        n_allocs  = 0;
        n_granted = 0;
        n_nofit   = 0;
        n_zero    = 0;
        n_frees   = 0;
        n_range   = 0;
        peak_pct  = 0;
        no_idle   = 1'b0;
        foreach (block_runs[k])
            block_runs[k] = 9'd0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_full_table_run();
        test_request_edges();
        test_release_edges();
        test_drain_pause();
        test_random_mix(RANDOM_ITEMS);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Allocations: %0d (%0d granted, %0d no fit, %0d zero size)",
                 n_allocs, n_granted, n_nofit, n_zero);
        $display("Releases: %0d (%0d outside pool); peak occupancy %0d%%, %0d mismatches",
                 n_frees, n_range, peak_pct, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
